### design/skiw_pkg.sv
// Package with the command, status and transaction types of the sorted key interpolation block.
`default_nettype none
package skiw_pkg;

  localparam int MAX_KEYS      = 16;
  localparam int POSITION_BITS = 24;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_SPARE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_INSERTED   = 3'd0,
    ST_FULL       = 3'd1,
    ST_EMPTY      = 3'd2,
    ST_CLAMP_LOW  = 3'd3,
    ST_CLAMP_HIGH = 3'd4,
    ST_INTERP     = 3'd5,
    ST_CLEARED    = 3'd6
  } status_e;

  typedef struct packed {
    logic [1:0]                     cmd;
    logic signed [POSITION_BITS-1:0] key_position;
    logic [7:0]                     key_tag;
    logic                           key_chromatic;
    logic signed [POSITION_BITS-1:0] control_value;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  lower_tag;
    logic [7:0]  upper_tag;
    logic [16:0] weight;
    logic        chromatic;
    logic [4:0]  key_count;
  } out_t;

endpackage
`default_nettype wire

### design/skiw_ram.sv
// Generic single-port RAM with a registered read.
`default_nettype none
module skiw_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

### design/sorted_key_interpolation_weights.sv
// Top level of the sorted key table with piecewise linear interpolation weights.
`default_nettype none
// One transaction at a time; busy is high from acceptance through the cycle of the result
// strobe. An insert scans the table from the top, reading each entry through the key memory
// and shifting it up one place while its key is not below the new key. A lookup scans from
// the bottom and clamps below the first key or above the last; otherwise an interpolation
// runs a restoring divider that forms one quotient bit per cycle. Clear, full and empty
// answer without reading the key memory.
// The result is shown for one cycle on done_o; the receiver cannot stall it.
module sorted_key_interpolation_weights (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire skiw_pkg::in_t  req_i,
  output logic                done_o,
  output skiw_pkg::out_t      rsp_o
);
  import skiw_pkg::*;

  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CW = $clog2(MAX_KEYS + 1);
  localparam int PB = POSITION_BITS;
  localparam int DW = PB + 1;
  localparam int EW = PB + 8;

  localparam logic [3:0] S_IDLE = 4'd0, S_IRD = 4'd1, S_IWAIT = 4'd2, S_ICHK = 4'd3,
                         S_IPUT = 4'd4, S_LRD = 4'd5, S_LWAIT = 4'd6, S_LCHK = 4'd7,
                         S_DIV = 4'd8, S_DONE = 4'd9, S_PREV = 4'd10, S_PWAIT = 4'd11;

  logic [3:0]  state_q, state_d;
  logic [CW-1:0] count_q, count_d, idx_q, idx_d;
  logic        chrom_q, chrom_d;
  in_t         req_q, req_d;
  logic signed [PB-1:0] k1_q, k1_d;
  logic [7:0]  t1_q, t1_d;
  out_t        rsp_q, rsp_d;
  logic        done_q, done_d;
  logic [DW+16:0] rem_q, rem_d;
  logic [16:0] quo_q, quo_d;
  logic [DW-1:0] den_q, den_d;
  logic [4:0]  bit_q, bit_d;

  logic          we;
  logic [AW-1:0] addr;
  logic [EW-1:0] wdata, rdata;
  logic signed [PB-1:0] rpos, ipos, cpos;
  logic [DW+16:0] trial;

  skiw_ram #(.Width(EW), .Depth(MAX_KEYS)) u_keys (
    .clk_i(clk_i), .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  assign rpos = rdata[EW-1:8];
  assign ipos = req_q.key_position[PB-1:0];
  assign cpos = req_q.control_value[PB-1:0];
  assign trial = {rem_q[DW+15:0], 1'b0} - {17'd0, den_q};

  always_comb begin
    state_d = state_q; count_d = count_q; idx_d = idx_q; chrom_d = chrom_q;
    req_d = req_q; k1_d = k1_q; t1_d = t1_q; rsp_d = rsp_q;
    done_d = 1'b0; rem_d = rem_q; quo_d = quo_q; den_d = den_q; bit_d = bit_q;
    we = 1'b0; addr = idx_q[AW-1:0]; wdata = '0;
    case (state_q)
      S_IDLE: begin
        if (start && !busy) begin
          req_d = req_i;
          rsp_d = '0;
          if (req_i.cmd == CMD_INSERT) begin
            if (count_q >= CW'(MAX_KEYS)) begin
              rsp_d.status = ST_FULL;
              state_d = S_DONE;
            end else begin
              idx_d = count_q;
              state_d = S_IRD;
            end
          end else if (req_i.cmd == CMD_CLEAR) begin
            count_d = '0;
            chrom_d = 1'b0;
            rsp_d.status = ST_CLEARED;
            state_d = S_DONE;
          end else if (count_q == '0) begin
            rsp_d.status = ST_EMPTY;
            state_d = S_DONE;
          end else begin
            idx_d = '0;
            state_d = S_LRD;
          end
        end
      end
      S_IRD: begin
        if (idx_q == '0) begin
          state_d = S_IPUT;
        end else begin
          addr = AW'(idx_q - CW'(1));
          state_d = S_IWAIT;
        end
      end
      S_IWAIT: begin
        addr = AW'(idx_q - CW'(1));
        state_d = S_ICHK;
      end
      S_ICHK: begin
        if (rpos < ipos) begin
          state_d = S_IPUT;
        end else begin
          we = 1'b1;
          wdata = rdata;
          idx_d = idx_q - CW'(1);
          state_d = S_IRD;
        end
      end
      S_IPUT: begin
        we = 1'b1;
        wdata = {ipos, req_q.key_tag};
        count_d = count_q + CW'(1);
        chrom_d = chrom_q | req_q.key_chromatic;
        rsp_d.status = ST_INSERTED;
        state_d = S_DONE;
      end
      S_LRD: state_d = S_LWAIT;
      S_LWAIT: state_d = S_LCHK;
      S_LCHK: begin
        if (!(rpos < cpos)) begin
          if (idx_q == '0) begin
            rsp_d.status = ST_CLAMP_LOW;
            rsp_d.lower_tag = rdata[7:0];
            rsp_d.upper_tag = rdata[7:0];
            state_d = S_DONE;
          end else begin
            k1_d = rpos;
            t1_d = rdata[7:0];
            idx_d = idx_q - CW'(1);
            state_d = S_PREV;
          end
        end else if (idx_q + CW'(1) >= count_q) begin
          rsp_d.status = ST_CLAMP_HIGH;
          rsp_d.lower_tag = rdata[7:0];
          rsp_d.upper_tag = rdata[7:0];
          rsp_d.weight = 17'h10000;
          state_d = S_DONE;
        end else begin
          idx_d = idx_q + CW'(1);
          addr = AW'(idx_q + CW'(1));
          state_d = S_LWAIT;
        end
      end
      S_PREV: state_d = S_PWAIT;
      S_PWAIT: begin
        rsp_d.status = ST_INTERP;
        rsp_d.lower_tag = rdata[7:0];
        rsp_d.upper_tag = t1_q;
        rem_d = {17'd0, DW'({cpos[PB-1], cpos}) - DW'({rpos[PB-1], rpos})};
        den_d = DW'({k1_q[PB-1], k1_q}) - DW'({rpos[PB-1], rpos});
        quo_d = '0;
        bit_d = 5'd17;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (bit_q == 5'd0) begin
          rsp_d.weight = (quo_q > 17'h10000) ? 17'h10000 : quo_q;
          state_d = S_DONE;
        end else begin
          if (bit_q > 5'd16) begin
            if (rem_q[DW-1:0] >= den_q) begin
              rem_d = rem_q - {17'd0, den_q};
              quo_d = 17'd1;
            end else begin
              quo_d = '0;
            end
          end else if (!trial[DW+16]) begin
            rem_d = trial;
            quo_d = {quo_q[15:0], 1'b1};
          end else begin
            rem_d = {rem_q[DW+15:0], 1'b0};
            quo_d = {quo_q[15:0], 1'b0};
          end
          bit_d = bit_q - 5'd1;
        end
      end
      S_DONE: begin
        rsp_d.chromatic = chrom_q;
        rsp_d.key_count = 5'(count_q);
        done_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      chrom_q <= 1'b0;
      done_q  <= 1'b0;
      idx_q   <= '0;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      chrom_q <= chrom_d;
      done_q  <= done_d;
      idx_q   <= idx_d;
      bit_q   <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d; k1_q <= k1_d; t1_q <= t1_d;
    rsp_q <= rsp_d; rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d;
  end

  assign busy   = (state_q != S_IDLE) || done_q;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_KEYS)) else $error("key count beyond table size");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("result strobe longer than one cycle");
  a_weight_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> rsp_q.weight <= 17'h10000) else $error("weight above one");
endmodule
`default_nettype wire
